FILE: hdl/lbc_pkg.sv
// Shared types, constants and helpers for the byte-budget LRU cache.
`default_nettype none
package lbc_pkg;

  localparam int CAPACITY    = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int HANDLE_BITS = 16;
  localparam logic [15:0] HANDLE_MASK = 16'((17'd1 << HANDLE_BITS) - 17'd1);

  typedef enum logic [1:0] {
    CMD_FIND  = 2'd0,
    CMD_STORE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OUT_HIT      = 3'd0,
    OUT_MISS     = 3'd1,
    OUT_STORED   = 3'd2,
    OUT_REJECTED = 3'd3,
    OUT_EVICTED  = 3'd4,
    OUT_CLEARED  = 3'd5
  } outcome_e;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_FILL,
    CELL_TOUCH,
    CELL_DROP,
    CELL_CLEAR
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SETTLE,
    S_EVCHK
  } state_e;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    cell_op_e          op;
    logic [IDX_W-1:0]  idx;
    logic [63:0]       key;
    logic [15:0]       handle;
    logic [31:0]       size;
    logic [63:0]       stamp;
    logic              skip_en;
    logic [IDX_W-1:0]  skip_idx;
  } cell_cmd_t;

  // Oldest-entry candidate handed down the chain
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [63:0]       stamp;
    logic [63:0]       key;
    logic [15:0]       handle;
    logic [31:0]       size;
  } best_t;

  // Slot contents seen by the controller
  typedef struct packed {
    logic        valid;
    logic        match;
    logic [15:0] handle;
    logic [31:0] size;
  } slot_t;

  // Subtract with floor at zero
  function automatic logic [31:0] drop_bytes(input logic [31:0] held, input logic [31:0] sz);
    drop_bytes = (sz <= held) ? held - sz : 32'd0;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/lbc_cell.sv
// One cache slot plus its stage of the oldest-entry search chain.
`default_nettype none
module lbc_cell import lbc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] my_idx,
  input  wire cell_cmd_t        cmd,
  input  wire best_t            prev,
  output best_t                 best,
  output slot_t                 slot
);

  logic        valid;
  logic [63:0] key;
  logic [15:0] handle;
  logic [31:0] size;
  logic [63:0] stamp;
  logic        sel;
  logic        cand;
  best_t       best_next;

  assign sel = (cmd.idx == my_idx);

  // Slot storage
  always_ff @(posedge clk) begin
    if (rst || cmd.op == CELL_CLEAR) begin
      valid <= 1'b0;
    end else if (sel) begin
      case (cmd.op)
        CELL_FILL: begin
          valid  <= 1'b1;
          key    <= cmd.key;
          handle <= cmd.handle;
          size   <= cmd.size;
          stamp  <= cmd.stamp;
        end
        CELL_TOUCH: stamp <= cmd.stamp;
        CELL_DROP:  valid <= 1'b0;
        default: ;
      endcase
    end
  end

  // Chain stage: keep upstream candidate unless this slot is strictly older
  assign cand = valid && !(cmd.skip_en && cmd.skip_idx == my_idx);

  always_comb begin
    best_next = prev;
    if (cand && (!prev.found || stamp < prev.stamp)) begin
      best_next.found  = 1'b1;
      best_next.idx    = my_idx;
      best_next.stamp  = stamp;
      best_next.key    = key;
      best_next.handle = handle;
      best_next.size   = size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best.found <= 1'b0;
    end else begin
      best.found <= best_next.found;
    end
    best.idx    <= best_next.idx;
    best.stamp  <= best_next.stamp;
    best.key    <= best_next.key;
    best.handle <= best_next.handle;
    best.size   <= best_next.size;
  end

  assign slot.valid  = valid;
  assign slot.match  = valid && (key == cmd.key);
  assign slot.handle = handle;
  assign slot.size   = size;

endmodule
`default_nettype wire

FILE: hdl/byte_budget_lru_cache.sv
// Find, clear, reserved-command and rejected store results are decided in S_LOOK and then registered.
// A store gives its eviction results first and its stored result last; each one is decided in S_EVCHK
// after S_SETTLE has let the oldest-entry chain settle.
// One transaction at a time: in_stall drops once the last result is loaded, and output stalls delay that.
// Synchronous reset empties all slots, counters, byte count and budget.
`default_nettype none
module byte_budget_lru_cache import lbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [63:0] lookup_key,
  input  wire logic [15:0] payload_handle,
  input  wire logic [31:0] payload_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       outcome,
  output logic [15:0]      result_handle,
  output logic [63:0]      result_key,
  output logic             last_of_run,
  output logic [31:0]      bytes_in_use,
  output logic [31:0]      hit_total,
  output logic [31:0]      miss_total,
  output logic [31:0]      store_total,
  output logic [31:0]      eviction_total,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  state_e state, state_next;

  // Latched transaction
  cmd_e        r_cmd;
  logic [63:0] r_key;
  logic [15:0] r_handle;
  logic [31:0] r_size;
  logic        hit_found, hit_found_next;
  logic [IDX_W-1:0] hit_idx, hit_idx_next;

  logic [31:0] byte_budget;
  logic [31:0] bytes_held, bytes_held_next;
  logic [63:0] use_clock, use_clock_next;
  logic [31:0] hits, hits_next, misses, misses_next;
  logic [31:0] stores, stores_next, evicts, evicts_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  cell_cmd_t cell_cmd;
  best_t     chain [CAPACITY+1];
  slot_t     slots [CAPACITY];

  logic             hit_c;
  logic [IDX_W-1:0] hit_idx_c;
  logic             all_valid;
  logic [IDX_W-1:0] free_idx;
  logic             out_free;
  logic             over;
  logic             emit;
  outcome_e         e_outcome;
  logic [15:0]      e_handle;
  logic [63:0]      e_key;
  logic             e_last;

  // Cell row
  assign chain[0] = '0;
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lbc_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .my_idx (IDX_W'(g)),
      .cmd    (cell_cmd),
      .prev   (chain[g]),
      .best   (chain[g+1]),
      .slot   (slots[g])
    );
  end

  // Key match and free-slot priority (lowest index wins)
  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    free_idx  = '0;
    all_valid = 1'b1;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (slots[i].match) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (!slots[i].valid) begin
        free_idx  = IDX_W'(i);
        all_valid = 1'b0;
      end
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign over = ({1'b0, bytes_held} + {1'b0, r_size}) > {1'b0, byte_budget};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, cell commands and results
  always_comb begin
    state_next      = state;
    hit_found_next  = hit_found;
    hit_idx_next    = hit_idx;
    bytes_held_next = bytes_held;
    use_clock_next  = use_clock;
    hits_next       = hits;
    misses_next     = misses;
    stores_next     = stores;
    evicts_next     = evicts;
    cnt_next        = cnt;
    emit            = 1'b0;
    e_outcome       = OUT_REJECTED;
    e_handle        = '0;
    e_key           = r_key;
    e_last          = 1'b1;
    cell_cmd          = '0;
    cell_cmd.op       = CELL_NOP;
    cell_cmd.key      = r_key;
    cell_cmd.handle   = r_handle;
    cell_cmd.size     = r_size;
    cell_cmd.skip_en  = hit_found;
    cell_cmd.skip_idx = hit_idx;
    cell_cmd.idx      = hit_idx;
    cell_cmd.stamp    = use_clock + 64'd1;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (r_cmd == CMD_STORE && byte_budget != 32'd0 && r_size != 32'd0 &&
            r_size <= byte_budget) begin
          hit_found_next = hit_c;
          hit_idx_next   = hit_idx_c;
          if (hit_c) begin
            bytes_held_next = drop_bytes(bytes_held, slots[hit_idx_c].size);
          end
          cnt_next   = '0;
          state_next = S_SETTLE;
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          case (r_cmd)
            CMD_FIND: begin
              if (hit_c) begin
                use_clock_next = use_clock + 64'd1;
                hits_next      = hits + 32'd1;
                cell_cmd.op    = CELL_TOUCH;
                cell_cmd.idx   = hit_idx_c;
                e_outcome      = OUT_HIT;
                e_handle       = slots[hit_idx_c].handle;
              end else begin
                misses_next = misses + 32'd1;
                e_outcome   = OUT_MISS;
              end
            end
            CMD_CLEAR: begin
              cell_cmd.op     = CELL_CLEAR;
              bytes_held_next = '0;
              use_clock_next  = '0;
              hits_next       = '0;
              misses_next     = '0;
              stores_next     = '0;
              evicts_next     = '0;
              e_outcome       = OUT_CLEARED;
            end
            default: e_outcome = OUT_REJECTED;
          endcase
        end
      end
      S_SETTLE: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(CAPACITY)) begin
          state_next = S_EVCHK;
        end
      end
      S_EVCHK: begin
        if (out_free) begin
          emit = 1'b1;
          if (chain[CAPACITY].found && (over || (!hit_found && all_valid))) begin
            cell_cmd.op     = CELL_DROP;
            cell_cmd.idx    = chain[CAPACITY].idx;
            bytes_held_next = drop_bytes(bytes_held, chain[CAPACITY].size);
            evicts_next     = evicts + 32'd1;
            e_outcome       = OUT_EVICTED;
            e_handle        = chain[CAPACITY].handle;
            e_key           = chain[CAPACITY].key;
            e_last          = 1'b0;
            cnt_next        = '0;
            state_next      = S_SETTLE;
          end else begin
            cell_cmd.op     = CELL_FILL;
            cell_cmd.idx    = hit_found ? hit_idx : free_idx;
            use_clock_next  = use_clock + 64'd1;
            bytes_held_next = bytes_held + r_size;
            stores_next     = stores + 32'd1;
            e_outcome       = OUT_STORED;
            state_next      = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_budget <= '0;
      bytes_held  <= '0;
      use_clock   <= '0;
      hits        <= '0;
      misses      <= '0;
      stores      <= '0;
      evicts      <= '0;
      hit_found   <= 1'b0;
      cnt         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        byte_budget <= cfg_data;
      end
      bytes_held <= bytes_held_next;
      use_clock  <= use_clock_next;
      hits       <= hits_next;
      misses     <= misses_next;
      stores     <= stores_next;
      evicts     <= evicts_next;
      hit_found  <= hit_found_next;
      cnt        <= cnt_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Transaction capture and result payload
  always_ff @(posedge clk) begin
    hit_idx <= hit_idx_next;
    if (state == S_IDLE && in_valid) begin
      r_cmd    <= cmd_e'(cmd);
      r_key    <= lookup_key;
      r_handle <= payload_handle & HANDLE_MASK;
      r_size   <= payload_bytes;
    end
    if (emit) begin
      outcome        <= e_outcome;
      result_handle  <= e_handle;
      result_key     <= e_key;
      last_of_run    <= e_last;
      bytes_in_use   <= bytes_held_next;
      hit_total      <= hits_next;
      miss_total     <= misses_next;
      store_total    <= stores_next;
      eviction_total <= evicts_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_LOOK))
    else $error("accepted transaction did not enter lookup");
  a_evict_found: assert property (@(posedge clk) disable iff (rst)
    (cell_cmd.op == CELL_DROP) |-> chain[CAPACITY].found)
    else $error("eviction without a valid oldest entry");
  a_clear_bytes: assert property (@(posedge clk) disable iff (rst)
    (emit && e_outcome == OUT_CLEARED) |=> (bytes_held == 32'd0 && use_clock == 64'd0))
    else $error("clear left bytes or clock nonzero");
  a_stored_last: assert property (@(posedge clk) disable iff (rst)
    (emit && e_outcome == OUT_STORED) |-> (e_last && state == S_EVCHK))
    else $error("stored result not final");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result overwrote a pending result");
`endif

endmodule
`default_nettype wire

FILE: dv/byte_budget_lru_cache_tb.sv
// Self-checking testbench for the byte-budget LRU cache: cache predictor plus result scoreboard.
`default_nettype none
module byte_budget_lru_cache_tb import lbc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [15:0] handle;
    logic [63:0] key;
    logic        last;
    logic [31:0] bytes_used;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] stores;
    logic [31:0] evictions;
  } cache_result_t;

  // Shadow cache and the queue of results it predicts
  class cache_scoreboard;
    bit          valid_q[CAPACITY];
    bit [63:0]   key_q[CAPACITY];
    bit [15:0]   handle_q[CAPACITY];
    bit [31:0]   size_q[CAPACITY];
    bit [63:0]   stamp_q[CAPACITY];
    bit [31:0]   held;
    bit [63:0]   tick;
    bit [31:0]   stats[4];
    bit [31:0]   budget;
    cache_result_t pending[$];
    int          errors;
    int          checked;
    int          evict_seen;

    function void reset_state();
      foreach (valid_q[i]) valid_q[i] = 0;
      foreach (stats[i]) stats[i] = 0;
      held = 0;
      tick = 0;
      budget = 0;
    endfunction

    function void reset_state_keep_budget();
      bit [31:0] b;
      b = budget;
      reset_state();
      budget = b;
    endfunction

    function void push(outcome_e oc, bit [15:0] h, bit [63:0] k);
      cache_result_t r;
      r.outcome = oc;
      r.handle = h;
      r.key = k;
      r.last = 0;
      r.bytes_used = held;
      r.hits = stats[0];
      r.misses = stats[1];
      r.stores = stats[2];
      r.evictions = stats[3];
      pending.push_back(r);
    endfunction

    function int oldest_slot(int skip);
      int best;
      best = -1;
      for (int i = 0; i < CAPACITY; i++)
        if (valid_q[i] && i != skip && (best < 0 || stamp_q[i] < stamp_q[best])) best = i;
      return best;
    endfunction

    function void drop(bit [31:0] sz);
      held = (sz <= held) ? held - sz : 32'd0;
    endfunction

    function void evict_slot(int s);
      drop(size_q[s]);
      valid_q[s] = 0;
      stats[3]++;
      push(OUT_EVICTED, handle_q[s], key_q[s]);
    endfunction

    // Predict every result of one accepted command
    function void note_command(bit [1:0] c, bit [63:0] k, bit [15:0] h, bit [31:0] sz);
      int hit, s, v, used, first;
      first = pending.size();
      hit = -1;
      h = h & HANDLE_MASK;
      for (int i = 0; i < CAPACITY; i++)
        if (hit < 0 && valid_q[i] && key_q[i] == k) hit = i;
      if (c == CMD_FIND) begin
        if (hit >= 0) begin
          tick++;
          stamp_q[hit] = tick;
          stats[0]++;
          push(OUT_HIT, handle_q[hit], k);
        end else begin
          stats[1]++;
          push(OUT_MISS, 16'd0, k);
        end
      end else if (c == CMD_CLEAR) begin
        reset_state_keep_budget();
        push(OUT_CLEARED, 16'd0, k);
      end else if (c == CMD_RSVD || budget == 0 || sz == 0 || sz > budget) begin
        push(OUT_REJECTED, 16'd0, k);
      end else begin
        s = hit;
        if (s >= 0) begin
          drop(size_q[s]);
          while (64'(held) + sz > budget) begin
            v = oldest_slot(s);
            if (v < 0) break;
            evict_slot(v);
          end
        end else begin
          while (64'(held) + sz > budget) begin
            v = oldest_slot(-1);
            if (v < 0) break;
            evict_slot(v);
          end
          used = 0;
          foreach (valid_q[i]) used += valid_q[i];
          if (used >= CAPACITY) begin
            v = oldest_slot(-1);
            if (v >= 0) evict_slot(v);
          end
          for (int i = CAPACITY - 1; i >= 0; i--)
            if (!valid_q[i]) s = i;
          if (s < 0) s = 0;
          valid_q[s] = 1;
          key_q[s] = k;
        end
        handle_q[s] = h;
        size_q[s] = sz;
        tick++;
        stamp_q[s] = tick;
        held = held + sz;
        stats[2]++;
        push(OUT_STORED, 16'd0, k);
      end
      pending[pending.size() - 1].last = 1;
    endfunction

    // Compare one observed result against the oldest prediction
    function void check_result(cache_result_t got);
      cache_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result outcome=%0d key=%h", got.outcome, got.key);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r.outcome == OUT_EVICTED) evict_seen++;
      if (got.outcome != exp_r.outcome) begin
        $error("outcome: exp %0d got %0d", exp_r.outcome, got.outcome); errors++;
      end
      if (got.handle != exp_r.handle) begin
        $error("result_handle: exp %h got %h", exp_r.handle, got.handle); errors++;
      end
      if (got.key != exp_r.key) begin
        $error("result_key: exp %h got %h", exp_r.key, got.key); errors++;
      end
      if (got.last != exp_r.last) begin
        $error("last_of_run: exp %0d got %0d", exp_r.last, got.last); errors++;
      end
      if (got.bytes_used != exp_r.bytes_used) begin
        $error("bytes_in_use: exp %0d got %0d", exp_r.bytes_used, got.bytes_used); errors++;
      end
      if (got.hits != exp_r.hits) begin
        $error("hit_total: exp %0d got %0d", exp_r.hits, got.hits); errors++;
      end
      if (got.misses != exp_r.misses) begin
        $error("miss_total: exp %0d got %0d", exp_r.misses, got.misses); errors++;
      end
      if (got.stores != exp_r.stores) begin
        $error("store_total: exp %0d got %0d", exp_r.stores, got.stores); errors++;
      end
      if (got.evictions != exp_r.evictions) begin
        $error("eviction_total: exp %0d got %0d", exp_r.evictions, got.evictions); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [63:0] lookup_key;
  logic [15:0] payload_handle;
  logic [31:0] payload_bytes;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  outcome;
  logic [15:0] result_handle;
  logic [63:0] result_key;
  logic        last_of_run;
  logic [31:0] bytes_in_use;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] store_total;
  logic [31:0] eviction_total;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  cache_scoreboard sb;
  int          cycles = 0;
  int          items_sent;
  logic [63:0] key_pool[8];
  int          burst_left;

  localparam int CYCLE_LIMIT = 600000;

  byte_budget_lru_cache u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .lookup_key(lookup_key),
    .payload_handle(payload_handle), .payload_bytes(payload_bytes),
    .out_valid(out_valid), .out_stall(out_stall),
    .outcome(outcome), .result_handle(result_handle), .result_key(result_key),
    .last_of_run(last_of_run), .bytes_in_use(bytes_in_use),
    .hit_total(hit_total), .miss_total(miss_total),
    .store_total(store_total), .eviction_total(eviction_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: stall pattern of its own, check on accepted results
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result({outcome, result_handle, result_key, last_of_run, bytes_in_use,
                         hit_total, miss_total, store_total, eviction_total});
      case (cycles[9:8])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Send one command; bursts of random length with random gaps between them
  task automatic send_cmd(input logic [1:0] c, input logic [63:0] k,
                          input logic [15:0] h, input logic [31:0] sz);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= c;
    lookup_key <= k;
    payload_handle <= h;
    payload_bytes <= sz;
    do @(posedge clk); while (in_stall);
    sb.note_command(c, k, h, sz);
    items_sent++;
  endtask

  // Drain outstanding results, then write the budget while idle
  task automatic write_budget(input logic [31:0] b);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.budget = b;
  endtask

  function automatic logic [31:0] pick_size(input logic [31:0] b);
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return b;
      2: return 32'($urandom) | 32'h8000_0000;
      default: return (b < 5) ? b : $urandom_range(1, (b / 3 > 1) ? b / 3 : 1);
    endcase
  endfunction

  // Mostly reused keys so finds hit and stores update; some fresh ones
  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 4) != 0) return key_pool[$urandom_range(0, 7)];
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(input int n_items, input logic [31:0] b);
    logic [1:0] c;
    int r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      c = (r < 55) ? CMD_STORE : (r < 93) ? CMD_FIND : (r < 96) ? CMD_CLEAR : CMD_RSVD;
      send_cmd(c, pick_key(), 16'($urandom), pick_size(b));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    items_sent = 0;
    burst_left = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_FIND;
    lookup_key = '0;
    payload_handle = '0;
    payload_bytes = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero budget rejects, unused command, miss, clear
    send_cmd(CMD_STORE, 64'd5, 16'hFFFF, 32'd10);
    send_cmd(CMD_RSVD, '1, 16'h0, 32'd1);
    send_cmd(CMD_FIND, '0, 16'h0, 32'd0);
    send_cmd(CMD_CLEAR, 64'hA5A5_5A5A_0F0F_F0F0, 16'h0, 32'd0);

    // Small budget: oversize and zero size rejects, evictions, update of held key
    write_budget(32'd100);
    send_cmd(CMD_STORE, 64'd1, 16'hFFFF, 32'd0);
    send_cmd(CMD_STORE, 64'd1, 16'hFFFF, 32'd101);
    send_cmd(CMD_STORE, '1, 16'hFFFF, 32'd40);
    send_cmd(CMD_STORE, 64'd0, 16'h0000, 32'd40);
    send_cmd(CMD_FIND, '1, 16'h0, 32'd0);
    send_cmd(CMD_STORE, 64'd7, 16'h1234, 32'd60);
    send_cmd(CMD_STORE, 64'd7, 16'h4321, 32'd100);
    send_cmd(CMD_FIND, 64'd7, 16'h0, 32'd0);

    // Budget lowered below what is held: entries stay until a store
    write_budget(32'd1);
    send_cmd(CMD_FIND, 64'd7, 16'h0, 32'd0);
    send_cmd(CMD_STORE, 64'd7, 16'hAAAA, 32'd1);
    send_cmd(CMD_STORE, 64'd8, 16'h5555, 32'd1);

    // Largest budget: fill the table past capacity
    write_budget(32'hFFFF_FFFF);
    for (int i = 0; i < CAPACITY + 2; i++)
      send_cmd(CMD_STORE, 64'(i + 100), 16'(i), 32'hFFFF_FFFF >> (i + 4));
    send_cmd(CMD_STORE, 64'd200, 16'hBEEF, 32'hFFFF_FFFF);

    // Random phases over several budgets
    write_budget(32'd1000);
    random_phase(40, 32'd1000);
    write_budget(32'd50);
    random_phase(40, 32'd50);
    write_budget(32'hFFFF_FFFF);
    random_phase(30, 32'hFFFF_FFFF);
    write_budget(32'd0);
    random_phase(8, 32'd10);
    write_budget(32'($urandom_range(20, 400)));
    random_phase(20, sb.budget);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d commands and %0d results, %0d of them evictions.",
             items_sent, sb.checked, sb.evict_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
hdl/lbc_pkg.sv
hdl/lbc_cell.sv
hdl/byte_budget_lru_cache.sv
dv/byte_budget_lru_cache_tb.sv
